// ----- design/hbp_pkg.sv -----
package hbp_pkg;

	typedef struct packed {
		logic [31:0] pc;
		logic        taken;
	} branch_t;

	typedef struct packed {
		logic predicted_taken;
		logic mispredicted;
		logic used_gshare;
	} result_t;

	// status from the queue and the back end, seen by the front end
	typedef struct packed {
		logic q_full;
		logic clearing;
	} stat_t;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 4;
	localparam int CntW     = 5;

	localparam logic [CfgIdxW-1:0] CFG_BIMODAL_BITS = 2'd0;
	localparam logic [CfgIdxW-1:0] CFG_GSHARE_BITS  = 2'd1;
	localparam logic [CfgIdxW-1:0] CFG_HISTORY_BITS = 2'd2;
	localparam logic [CfgIdxW-1:0] CFG_CHOOSER_BITS = 2'd3;

	localparam logic [CfgDataW-1:0] RST_BIMODAL_BITS = 4'd12;
	localparam logic [CfgDataW-1:0] RST_GSHARE_BITS  = 4'd12;
	localparam logic [CfgDataW-1:0] RST_HISTORY_BITS = 4'd0;
	localparam logic [CfgDataW-1:0] RST_CHOOSER_BITS = 4'd0;

	localparam logic [1:0] CTR_MIN         = 2'd0;
	localparam logic [1:0] CTR_MAX         = 2'd3;
	localparam logic [1:0] CTR_WEAK_TAKEN  = 2'd2;
	localparam logic [1:0] CTR_WEAK_BIMODAL = 2'd1;

	localparam int QDepth = 2;

	// 2-bit saturating counter step
	function automatic logic [1:0] train(logic [1:0] ctr, logic up);
		logic [1:0] r;
		if (up) begin
			r = (ctr == CTR_MAX) ? CTR_MAX : ctr + 2'd1;
		end else begin
			r = (ctr == CTR_MIN) ? CTR_MIN : ctr - 2'd1;
		end
		return r;
	endfunction

	function automatic logic [31:0] low_mask(logic [CntW-1:0] bits);
		logic [31:0] m;
		for (int i = 0; i < 32; i++) begin
			m[i] = (CntW'(i) < bits);
		end
		return m;
	endfunction

	function automatic logic [CntW-1:0] clamp(logic [CfgDataW-1:0] v, logic [CntW-1:0] hi);
		logic [CntW-1:0] ve;
		ve = CntW'(v);
		return (ve > hi) ? hi : ve;
	endfunction

endpackage

// ----- design/hybrid_branch_predictor_top.sv -----
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-------------------------------
// branch    | start, busy (item taken when  | branch : hbp_pkg::branch_t
//           | start high and busy low)      |   (pc, taken)
// result    | done (one-cycle strobe)       | result : hbp_pkg::result_t
// config    | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// In the back end each item gets a registered counter memory read at pop,
// then the EVAL state predicts, trains and writes back. A new item is
// popped only once the last is written back; a two-entry queue lets up
// to three items be in flight. Each result is registered after EVAL.
// After reset the back end clears all counter memories, one entry per
// cycle over 2**max(MAX_*_BITS) entries (4096 by default); busy stays
// high during that pass. The receiver cannot stall: done is a single pulse.
module hybrid_branch_predictor_top #(
	parameter int MAX_BIMODAL_BITS = 12,
	parameter int MAX_GSHARE_BITS  = 12,
	parameter int MAX_CHOOSER_BITS = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  hbp_pkg::branch_t             branch,
	output logic                         done,
	output hbp_pkg::result_t             result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [hbp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [hbp_pkg::CfgDataW-1:0] cfg_data
);

	// queued item: bimodal index, gshare index, chooser index, outcome, mode
	localparam int ItemW = MAX_BIMODAL_BITS + MAX_GSHARE_BITS + MAX_CHOOSER_BITS + 3;

	hbp_pkg::stat_t   stat;
	logic             push, pop, q_full, q_empty, clearing;
	logic [ItemW-1:0] item_in, item_out;

	// configuration registers take a write in any cycle
	assign cfg_ready = 1'b1;
	assign stat      = '{q_full: q_full, clearing: clearing};

	// front end: hold config and history, build the table indices
	hbp_front #(
		.MAX_BIMODAL_BITS(MAX_BIMODAL_BITS),
		.MAX_GSHARE_BITS (MAX_GSHARE_BITS),
		.MAX_CHOOSER_BITS(MAX_CHOOSER_BITS),
		.ItemW           (ItemW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.branch   (branch),
		.busy     (busy),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.stat     (stat),
		.push     (push),
		.item     (item_in)
	);

	// decouple the front end from the memory back end
	hbp_queue #(
		.Width(ItemW)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (item_in),
		.pop   (pop),
		.dout  (item_out),
		.full  (q_full),
		.empty (q_empty)
	);

	// back end: read counters, predict, train, report
	hbp_back #(
		.MAX_BIMODAL_BITS(MAX_BIMODAL_BITS),
		.MAX_GSHARE_BITS (MAX_GSHARE_BITS),
		.MAX_CHOOSER_BITS(MAX_CHOOSER_BITS),
		.ItemW           (ItemW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.item    (item_out),
		.pop     (pop),
		.clearing(clearing),
		.done    (done),
		.result  (result)
	);

endmodule

// ----- design/hbp_queue.sv -----
module hbp_queue #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] din,
	input  logic             pop,
	output logic [Width-1:0] dout,
	output logic             full,
	output logic             empty
);

	localparam int PtrW = (hbp_pkg::QDepth > 1) ? $clog2(hbp_pkg::QDepth) : 1;
	localparam logic [PtrW:0] DepthC = (PtrW+1)'(hbp_pkg::QDepth);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(hbp_pkg::QDepth - 1);

	logic [Width-1:0] data_q [hbp_pkg::QDepth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [PtrW:0]    count_q;

	assign full  = (count_q == DepthC);
	assign empty = (count_q == '0);
	assign dout  = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/hbp_front.sv -----
module hbp_front #(
	parameter int MAX_BIMODAL_BITS = 12,
	parameter int MAX_GSHARE_BITS  = 12,
	parameter int MAX_CHOOSER_BITS = 12,
	parameter int ItemW = MAX_BIMODAL_BITS + MAX_GSHARE_BITS + MAX_CHOOSER_BITS + 3
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  hbp_pkg::branch_t                  branch,
	output logic                              busy,
	input  logic                              cfg_valid,
	input  logic [hbp_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [hbp_pkg::CfgDataW-1:0]      cfg_data,
	input  hbp_pkg::stat_t                    stat,
	output logic                              push,
	output logic [ItemW-1:0]                  item
);

	localparam logic [hbp_pkg::CntW-1:0] MaxB = hbp_pkg::CntW'(MAX_BIMODAL_BITS);
	localparam logic [hbp_pkg::CntW-1:0] MaxG = hbp_pkg::CntW'(MAX_GSHARE_BITS);
	localparam logic [hbp_pkg::CntW-1:0] MaxC = hbp_pkg::CntW'(MAX_CHOOSER_BITS);

	logic [hbp_pkg::CfgDataW-1:0] bim_bits_q, gsh_bits_q, hist_bits_q, cho_bits_q;
	logic [MAX_GSHARE_BITS-1:0]   hist_q;

	logic [hbp_pkg::CntW-1:0] m2, m1c, m1, n, k, lb;
	logic [29:0]              pcw;
	logic [31:0]              mask_b, mask_g, mask_n, mask_c;
	logic [MAX_BIMODAL_BITS-1:0] bi;
	logic [MAX_GSHARE_BITS-1:0]  gi, hist, hist_next;
	logic [MAX_GSHARE_BITS:0]    hist_ext;
	logic [MAX_CHOOSER_BITS-1:0] ci;
	logic                        hist_on, chooser_on;

	assign busy = stat.q_full | stat.clearing;
	assign push = start & ~busy;

	always_comb begin
		pcw = branch.pc[31:2];
		m2  = hbp_pkg::clamp(bim_bits_q, MaxB);
		m1c = hbp_pkg::clamp(gsh_bits_q, MaxG);
		m1  = (m1c == '0) ? hbp_pkg::CntW'(1) : m1c;
		n   = hbp_pkg::clamp(hist_bits_q, m1);
		k   = hbp_pkg::clamp(cho_bits_q, MaxC);
		lb  = m1 - n;

		mask_b = hbp_pkg::low_mask(m2);
		mask_g = hbp_pkg::low_mask(m1);
		mask_n = hbp_pkg::low_mask(n);
		mask_c = hbp_pkg::low_mask(k);

		bi   = pcw[MAX_BIMODAL_BITS-1:0] & mask_b[MAX_BIMODAL_BITS-1:0];
		ci   = pcw[MAX_CHOOSER_BITS-1:0] & mask_c[MAX_CHOOSER_BITS-1:0];
		hist = hist_q & mask_n[MAX_GSHARE_BITS-1:0];
		// history lands on the top n bits of the m1-bit index
		gi   = (pcw[MAX_GSHARE_BITS-1:0] & mask_g[MAX_GSHARE_BITS-1:0]) ^ (hist << lb);

		// shift the outcome in at bit n-1
		hist_ext = {1'b0, hist};
		for (int i = 0; i < MAX_GSHARE_BITS; i++) begin
			if (hbp_pkg::CntW'(i + 1) == n) begin
				hist_next[i] = branch.taken;
			end else if (hbp_pkg::CntW'(i + 1) < n) begin
				hist_next[i] = hist_ext[i+1];
			end else begin
				hist_next[i] = 1'b0;
			end
		end

		hist_on    = (n != '0);
		chooser_on = (k != '0);
		item = {bi, gi, ci, branch.taken, hist_on, chooser_on};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bim_bits_q  <= hbp_pkg::RST_BIMODAL_BITS;
			gsh_bits_q  <= hbp_pkg::RST_GSHARE_BITS;
			hist_bits_q <= hbp_pkg::RST_HISTORY_BITS;
			cho_bits_q  <= hbp_pkg::RST_CHOOSER_BITS;
			hist_q      <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					hbp_pkg::CFG_BIMODAL_BITS: bim_bits_q  <= cfg_data;
					hbp_pkg::CFG_GSHARE_BITS:  gsh_bits_q  <= cfg_data;
					hbp_pkg::CFG_HISTORY_BITS: hist_bits_q <= cfg_data;
					hbp_pkg::CFG_CHOOSER_BITS: cho_bits_q  <= cfg_data;
				endcase
			end
			if (push && hist_on) begin
				hist_q <= hist_next;
			end
		end
	end

endmodule

// ----- design/hbp_back.sv -----
module hbp_back #(
	parameter int MAX_BIMODAL_BITS = 12,
	parameter int MAX_GSHARE_BITS  = 12,
	parameter int MAX_CHOOSER_BITS = 12,
	parameter int ItemW = MAX_BIMODAL_BITS + MAX_GSHARE_BITS + MAX_CHOOSER_BITS + 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  logic [ItemW-1:0]  item,
	output logic              pop,
	output logic              clearing,
	output logic              done,
	output hbp_pkg::result_t  result
);

	localparam int BimDepth = 1 << MAX_BIMODAL_BITS;
	localparam int GshDepth = 1 << MAX_GSHARE_BITS;
	localparam int ChoDepth = 1 << MAX_CHOOSER_BITS;
	localparam int MaxBG = (MAX_BIMODAL_BITS > MAX_GSHARE_BITS) ? MAX_BIMODAL_BITS
		: MAX_GSHARE_BITS;
	localparam int ClrW  = (MaxBG > MAX_CHOOSER_BITS) ? MaxBG : MAX_CHOOSER_BITS;
	localparam int OffC  = 3;
	localparam int OffG  = OffC + MAX_CHOOSER_BITS;
	localparam int OffB  = OffG + MAX_GSHARE_BITS;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_EVAL  = 2'd2;

	logic [1:0] bim_mem [BimDepth];
	logic [1:0] gsh_mem [GshDepth];
	logic [1:0] cho_mem [ChoDepth];

	logic [1:0]       state_q;
	logic [ClrW-1:0]  clr_q;
	logic [ItemW-1:0] item_q;
	logic [1:0]       bim_rd_q, gsh_rd_q, cho_rd_q;
	logic             done_q;
	hbp_pkg::result_t result_q;

	logic eval, taken, hist_on, chooser_on, bpred, gpred, use_g, pred, g_ok, b_ok;
	logic bim_we, gsh_we, cho_we;
	logic [MAX_BIMODAL_BITS-1:0] bim_wa;
	logic [MAX_GSHARE_BITS-1:0]  gsh_wa;
	logic [MAX_CHOOSER_BITS-1:0] cho_wa;
	logic [1:0] bim_wd, gsh_wd, cho_wd;

	assign clearing = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign eval     = (state_q == ST_EVAL);
	assign done     = done_q;
	assign result   = result_q;

	always_comb begin
		chooser_on = item_q[0];
		hist_on    = item_q[1];
		taken      = item_q[2];
		bpred      = bim_rd_q[1];
		gpred      = gsh_rd_q[1];
		use_g      = hist_on & (~chooser_on | cho_rd_q[1]);
		pred       = use_g ? gpred : bpred;
		g_ok       = (gpred == taken);
		b_ok       = (bpred == taken);

		bim_we = clearing | (eval & ~use_g);
		gsh_we = clearing | (eval & use_g);
		cho_we = clearing | (eval & hist_on & chooser_on & (g_ok != b_ok));
		bim_wa = clearing ? clr_q[MAX_BIMODAL_BITS-1:0] : item_q[OffB +: MAX_BIMODAL_BITS];
		gsh_wa = clearing ? clr_q[MAX_GSHARE_BITS-1:0]  : item_q[OffG +: MAX_GSHARE_BITS];
		cho_wa = clearing ? clr_q[MAX_CHOOSER_BITS-1:0] : item_q[OffC +: MAX_CHOOSER_BITS];
		bim_wd = clearing ? hbp_pkg::CTR_WEAK_TAKEN : hbp_pkg::train(bim_rd_q, taken);
		gsh_wd = clearing ? hbp_pkg::CTR_WEAK_TAKEN : hbp_pkg::train(gsh_rd_q, taken);
		cho_wd = clearing ? hbp_pkg::CTR_WEAK_BIMODAL : hbp_pkg::train(cho_rd_q, g_ok);
	end

	// counter memories: one registered read at pop, one write per cycle
	always_ff @(posedge clk) begin
		if (pop) begin
			bim_rd_q <= bim_mem[item[OffB +: MAX_BIMODAL_BITS]];
			gsh_rd_q <= gsh_mem[item[OffG +: MAX_GSHARE_BITS]];
			cho_rd_q <= cho_mem[item[OffC +: MAX_CHOOSER_BITS]];
			item_q   <= item;
		end
		if (bim_we) begin
			bim_mem[bim_wa] <= bim_wd;
		end
		if (gsh_we) begin
			gsh_mem[gsh_wa] <= gsh_wd;
		end
		if (cho_we) begin
			cho_mem[cho_wa] <= cho_wd;
		end
		if (eval) begin
			result_q <= '{predicted_taken: pred, mispredicted: pred ^ taken, used_gshare: use_g};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= eval;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- design/hbp_checker.sv -----
module hbp_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic done
);

	localparam logic [2:0] MaxInFlight = 3'(hbp_pkg::QDepth + 1);

	logic       accept;
	logic [2:0] outstanding_q;

	assign accept = start & ~busy;

	// count items accepted but not yet reported
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else begin
			outstanding_q <= outstanding_q + 3'(accept) - 3'(done);
		end
	end

	// a result always belongs to an earlier accepted item
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> outstanding_q != '0)
		else $error("result without an accepted item");

	// queue plus back end bound the items in flight
	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		outstanding_q <= MaxInFlight)
		else $error("too many items in flight");

	// the back end finishes one item before it pops the next
	a_strobe_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results on two consecutive cycles");

	// the clearing pass holds off items right after reset
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> busy)
		else $error("item accepted during memory clear");

endmodule

bind hybrid_branch_predictor_top hbp_checker u_hbp_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);
